[sv/msc_pkg.sv]
// Shared types, widths and helpers for the matting sample-pair cost block.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package msc_pkg;

  // Build-time knobs
  localparam int COORD_BITS     = 12;
  localparam int COST_FRAC_BITS = 16;

  // Fixed field widths
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 3 * CH_W;
  localparam int COORD_IN_W = 12;
  localparam int NEAR_W     = 21;
  localparam int COST_W     = 30;
  localparam int ALPHA_W    = 16;
  localparam int ALPHA_FRAC = 15;
  localparam int IN_W       = 216;
  localparam int OUT_W      = 48;

  localparam logic [COST_W-1:0]  COST_MAX  = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC;

  // Colour path widths
  localparam int DIFF_W  = CH_W + 1;                 // signed channel difference
  localparam int NUM_W   = 2 * CH_W + 3;             // signed projection numerator
  localparam int DEN_W   = 2 * CH_W + 2;             // squared colour distance
  localparam int RES_W   = CH_W + ALPHA_FRAC + 2;    // signed residual, Q.15
  localparam int SQ_W    = 2 * (RES_W - 1);
  localparam int SUM2_W  = SQ_W + 2;
  localparam int CSH_L   = (COST_FRAC_BITS >= 15) ? 2 * (COST_FRAC_BITS - 15) : 0;
  localparam int CSH_R   = (COST_FRAC_BITS < 15) ? 2 * (15 - COST_FRAC_BITS) : 0;
  localparam int CSQ_W   = SUM2_W + CSH_L;
  localparam int CROOT_W = (CSQ_W + 1) / 2;

  // Spatial path widths
  localparam int COORD_W   = (COORD_BITS < COORD_IN_W) ? COORD_BITS : COORD_IN_W;
  localparam int DCO_W     = COORD_W + 1;
  localparam int D2_W      = 2 * COORD_W + 1;
  localparam int RAD_SHIFT = 32;
  localparam int SRAD_W    = D2_W + RAD_SHIFT;
  localparam int SROOT_W   = (SRAD_W + 1) / 2;
  localparam int SNUM_W    = SROOT_W + COST_FRAC_BITS - 8;
  localparam int SDIV_W    = (SNUM_W > NEAR_W + COST_W) ? SNUM_W : NEAR_W + COST_W;

  // Pipeline lengths
  localparam int COLOR_LEN  = 1 + ALPHA_FRAC + 3 + CROOT_W;
  localparam int SPACE_LEN  = SROOT_W + 1 + COST_W;
  localparam int PIPE_LEN   = (COLOR_LEN > SPACE_LEN) ? COLOR_LEN : SPACE_LEN;
  localparam int COLOR_PAD  = PIPE_LEN - COLOR_LEN;
  localparam int SPACE_PAD  = PIPE_LEN - SPACE_LEN;
  localparam int PIPE_DEPTH = PIPE_LEN + 3;

  typedef enum logic [1:0] {
    ASEL_ZERO = 2'd0,
    ASEL_ONE  = 2'd1,
    ASEL_DIV  = 2'd2
  } alpha_sel_t;

  // Input request, last field in the lowest bits
  typedef struct packed {
    logic [COST_W-1:0]     best_cost;
    logic [NEAR_W-1:0]     bg_nearest;
    logic [NEAR_W-1:0]     fg_nearest;
    logic [COORD_IN_W-1:0] bg_y;
    logic [COORD_IN_W-1:0] bg_x;
    logic [COORD_IN_W-1:0] fg_y;
    logic [COORD_IN_W-1:0] fg_x;
    logic [COORD_IN_W-1:0] pixel_y;
    logic [COORD_IN_W-1:0] pixel_x;
    logic [COLOR_W-1:0]    pixel_color;
    logic [COLOR_W-1:0]    bg_color;
    logic [COLOR_W-1:0]    fg_color;
  } in_item_t;

  // Result request, last field in the lowest bits
  typedef struct packed {
    logic                spare;
    logic                better;
    logic [COST_W-1:0]   cost;
    logic [ALPHA_W-1:0]  alpha;
  } out_item_t;

  typedef struct packed {
    logic [NUM_W-1:0]             num;
    logic [DEN_W-1:0]             den;
    logic [2:0][DIFF_W-1:0]       d;
    logic [2:0][DIFF_W-1:0]       e;
  } color_in_t;

  typedef struct packed {
    logic [D2_W-1:0]   d2;
    logic [NEAR_W-1:0] nearest;
  } space_in_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/msc_front.sv]
// First stage: channel differences, projection terms and squared distances.
// Depends on msc_pkg.
`default_nettype none

module msc_front (
  input  logic                  clk,
  input  logic                  adv_i,
  input  msc_pkg::in_item_t     item_i,
  output msc_pkg::color_in_t    col_o,
  output msc_pkg::space_in_t    spf_o,
  output msc_pkg::space_in_t    spb_o
);

  localparam int CH_W   = msc_pkg::CH_W;
  localparam int DIFF_W = msc_pkg::DIFF_W;
  localparam int NUM_W  = msc_pkg::NUM_W;
  localparam int DEN_W  = msc_pkg::DEN_W;
  localparam int CW     = msc_pkg::COORD_W;
  localparam int DCO_W  = msc_pkg::DCO_W;
  localparam int D2_W   = msc_pkg::D2_W;

  msc_pkg::color_in_t col_w;
  logic [D2_W-1:0]    d2f_w, d2b_w;

  always_comb begin
    logic signed [DIFF_W-1:0] dc, ec;
    logic signed [NUM_W-1:0]  pn, pd;
    col_w = '0;
    for (int c = 0; c < 3; c++) begin
      dc = $signed({1'b0, item_i.fg_color[CH_W*c +: CH_W]})
         - $signed({1'b0, item_i.bg_color[CH_W*c +: CH_W]});
      ec = $signed({1'b0, item_i.pixel_color[CH_W*c +: CH_W]})
         - $signed({1'b0, item_i.bg_color[CH_W*c +: CH_W]});
      pn = ec * dc;
      pd = dc * dc;
      col_w.d[c] = dc;
      col_w.e[c] = ec;
      col_w.num  = col_w.num + pn;
      col_w.den  = col_w.den + DEN_W'(pd);
    end
  end

  always_comb begin
    logic signed [DCO_W-1:0]   dx, dy;
    logic signed [2*DCO_W-1:0] sx, sy;
    dx = $signed({1'b0, item_i.pixel_x[CW-1:0]}) - $signed({1'b0, item_i.fg_x[CW-1:0]});
    dy = $signed({1'b0, item_i.pixel_y[CW-1:0]}) - $signed({1'b0, item_i.fg_y[CW-1:0]});
    sx = dx * dx;
    sy = dy * dy;
    d2f_w = D2_W'(sx) + D2_W'(sy);
    dx = $signed({1'b0, item_i.pixel_x[CW-1:0]}) - $signed({1'b0, item_i.bg_x[CW-1:0]});
    dy = $signed({1'b0, item_i.pixel_y[CW-1:0]}) - $signed({1'b0, item_i.bg_y[CW-1:0]});
    sx = dx * dx;
    sy = dy * dy;
    d2b_w = D2_W'(sx) + D2_W'(sy);
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      col_o         <= col_w;
      spf_o.d2      <= d2f_w;
      spf_o.nearest <= item_i.fg_nearest;
      spb_o.d2      <= d2b_w;
      spb_o.nearest <= item_i.bg_nearest;
    end
  end

endmodule

`default_nettype wire

[sv/msc_color.sv]
// Colour path: alpha divider, residual, squares and a digit-per-stage root.
// Depends on msc_pkg; padded to the common pipeline length.
`default_nettype none

module msc_color (
  input  logic                                clk,
  input  logic                                adv_i,
  input  msc_pkg::color_in_t                  col_i,
  output logic [msc_pkg::ALPHA_W-1:0]         alpha_o,
  output logic [msc_pkg::CROOT_W-1:0]         color_o
);

  localparam int AF     = msc_pkg::ALPHA_FRAC;
  localparam int AW     = msc_pkg::ALPHA_W;
  localparam int DEN_W  = msc_pkg::DEN_W;
  localparam int DIFF_W = msc_pkg::DIFF_W;
  localparam int RES_W  = msc_pkg::RES_W;
  localparam int SQ_W   = msc_pkg::SQ_W;
  localparam int SUM2_W = msc_pkg::SUM2_W;
  localparam int CSQ_W  = msc_pkg::CSQ_W;
  localparam int CR_W   = msc_pkg::CROOT_W;
  localparam int PAD    = msc_pkg::COLOR_PAD;

  // Alpha divider, index 0 is the classify stage
  logic [DEN_W:0]           rem_r [AF+1];
  logic [AF-1:0]            quo_r [AF+1];
  logic [DEN_W-1:0]         den_r [AF+1];
  logic [2:0][DIFF_W-1:0]   dv_r  [AF+1];
  logic [2:0][DIFF_W-1:0]   ev_r  [AF+1];
  msc_pkg::alpha_sel_t      sel_r [AF+1];

  always_ff @(posedge clk) begin
    if (adv_i) begin
      rem_r[0] <= (DEN_W+1)'(col_i.num);
      quo_r[0] <= '0;
      den_r[0] <= col_i.den;
      dv_r[0]  <= col_i.d;
      ev_r[0]  <= col_i.e;
      priority if ($signed(col_i.num) <= 0)
        sel_r[0] <= msc_pkg::ASEL_ZERO;
      else if ((DEN_W+1)'(col_i.num) >= {1'b0, col_i.den})
        sel_r[0] <= msc_pkg::ASEL_ONE;
      else
        sel_r[0] <= msc_pkg::ASEL_DIV;
    end
  end

  for (genvar k = 0; k < AF; k++) begin : g_adiv
    logic [DEN_W:0] twice;
    logic           ge;
    assign twice = {rem_r[k][DEN_W-1:0], 1'b0};
    assign ge    = twice >= {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      if (adv_i) begin
        rem_r[k+1] <= ge ? twice - {1'b0, den_r[k]} : twice;
        quo_r[k+1] <= {quo_r[k][AF-2:0], ge};
        den_r[k+1] <= den_r[k];
        dv_r[k+1]  <= dv_r[k];
        ev_r[k+1]  <= ev_r[k];
        sel_r[k+1] <= sel_r[k];
      end
    end
  end

  logic [AW-1:0] alpha_w;
  always_comb begin
    unique case (sel_r[AF])
      msc_pkg::ASEL_ZERO: alpha_w = '0;
      msc_pkg::ASEL_ONE:  alpha_w = msc_pkg::ALPHA_ONE;
      msc_pkg::ASEL_DIV:  alpha_w = {1'b0, quo_r[AF]};
      default:            alpha_w = '0;
    endcase
  end

  // Residual e*1.0 - alpha*d per channel
  logic [2:0][RES_W-1:0] res_w, res_r;
  logic [AW-1:0]         alpha_res_r;
  always_comb begin
    logic signed [RES_W-1:0]  ex;
    logic signed [AW+DIFF_W:0] prod;
    for (int c = 0; c < 3; c++) begin
      ex       = RES_W'($signed(ev_r[AF][c])) <<< AF;
      prod     = $signed({1'b0, alpha_w}) * $signed(dv_r[AF][c]);
      res_w[c] = ex - RES_W'(prod);
    end
  end

  // Squares
  logic [2:0][SQ_W-1:0] sq_w, sq_r;
  logic [AW-1:0]        alpha_sq_r;
  always_comb begin
    logic signed [2*RES_W-1:0] p;
    for (int c = 0; c < 3; c++) begin
      p       = $signed(res_r[c]) * $signed(res_r[c]);
      sq_w[c] = SQ_W'(p);
    end
  end

  // Sum, rescale, then root one digit per stage; index 0 holds the radicand
  logic [SUM2_W-1:0] sum2_w;
  logic [CSQ_W-1:0]  srem_r  [CR_W+1];
  logic [CR_W-1:0]   sroot_r [CR_W+1];
  logic [AW-1:0]     salpha_r [CR_W+1];
  assign sum2_w = SUM2_W'(sq_r[0]) + SUM2_W'(sq_r[1]) + SUM2_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (adv_i) begin
      res_r       <= res_w;
      alpha_res_r <= alpha_w;
      sq_r        <= sq_w;
      alpha_sq_r  <= alpha_res_r;
      srem_r[0]   <= CSQ_W'(sum2_w >> msc_pkg::CSH_R) << msc_pkg::CSH_L;
      sroot_r[0]  <= '0;
      salpha_r[0] <= alpha_sq_r;
    end
  end

  for (genvar k = 0; k < CR_W; k++) begin : g_root
    localparam int B = CR_W - 1 - k;
    logic [CSQ_W+1:0] cand;
    logic             ge;
    assign cand = ((CSQ_W+2)'(sroot_r[k]) << (B + 1)) + ((CSQ_W+2)'(1) << (2 * B));
    assign ge   = {2'b00, srem_r[k]} >= cand;
    always_ff @(posedge clk) begin
      if (adv_i) begin
        srem_r[k+1]   <= ge ? CSQ_W'({2'b00, srem_r[k]} - cand) : srem_r[k];
        sroot_r[k+1]  <= ge ? (sroot_r[k] | (CR_W'(1) << B)) : sroot_r[k];
        salpha_r[k+1] <= salpha_r[k];
      end
    end
  end

  if (PAD > 0) begin : g_pad
    logic [AW-1:0]   palpha_r [PAD];
    logic [CR_W-1:0] pcolor_r [PAD];
    always_ff @(posedge clk) begin
      if (adv_i) begin
        palpha_r[0] <= salpha_r[CR_W];
        pcolor_r[0] <= sroot_r[CR_W];
        for (int i = 1; i < PAD; i++) begin
          palpha_r[i] <= palpha_r[i-1];
          pcolor_r[i] <= pcolor_r[i-1];
        end
      end
    end
    assign alpha_o = palpha_r[PAD-1];
    assign color_o = pcolor_r[PAD-1];
  end else begin : g_nopad
    assign alpha_o = salpha_r[CR_W];
    assign color_o = sroot_r[CR_W];
  end

endmodule

`default_nettype wire

[sv/msc_space.sv]
// Spatial term: root of the scaled squared distance, then a quotient by the
// nearest-boundary distance, one bit per stage. Depends on msc_pkg.
`default_nettype none

module msc_space (
  input  logic                          clk,
  input  logic                          adv_i,
  input  msc_pkg::space_in_t            sp_i,
  output logic [msc_pkg::COST_W-1:0]    term_o
);

  localparam int RW  = msc_pkg::SRAD_W;
  localparam int SW  = msc_pkg::SROOT_W;
  localparam int DW  = msc_pkg::SDIV_W;
  localparam int QW  = msc_pkg::COST_W;
  localparam int NW  = msc_pkg::NEAR_W;
  localparam int PAD = msc_pkg::SPACE_PAD;

  logic [RW-1:0] rrem_r  [SW];
  logic [SW-1:0] root_r  [SW];
  logic [NW-1:0] rnear_r [SW];
  logic          rzero_r [SW];

  for (genvar k = 0; k < SW; k++) begin : g_root
    localparam int B = SW - 1 - k;
    logic [RW-1:0] rem_in;
    logic [SW-1:0] root_in;
    logic [NW-1:0] near_in;
    logic          zero_in;
    logic [RW+1:0] cand;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_in  = {sp_i.d2, {msc_pkg::RAD_SHIFT{1'b0}}};
      assign root_in = '0;
      assign near_in = sp_i.nearest;
      assign zero_in = (sp_i.d2 == '0);
    end else begin : g_next
      assign rem_in  = rrem_r[k-1];
      assign root_in = root_r[k-1];
      assign near_in = rnear_r[k-1];
      assign zero_in = rzero_r[k-1];
    end
    assign cand = ((RW+2)'(root_in) << (B + 1)) + ((RW+2)'(1) << (2 * B));
    assign ge   = {2'b00, rem_in} >= cand;
    always_ff @(posedge clk) begin
      if (adv_i) begin
        rrem_r[k]  <= ge ? RW'({2'b00, rem_in} - cand) : rem_in;
        root_r[k]  <= ge ? (root_in | (SW'(1) << B)) : root_in;
        rnear_r[k] <= near_in;
        rzero_r[k] <= zero_in;
      end
    end
  end

  // Scale, flag a zero divisor or overflow of the quotient range, then divide
  logic [DW-1:0] num_w, lim_w;
  assign num_w = DW'(root_r[SW-1]) << (msc_pkg::COST_FRAC_BITS - 8);
  assign lim_w = DW'(rnear_r[SW-1]) << QW;

  logic [DW-1:0] drem_r  [QW+1];
  logic [QW-1:0] quo_r   [QW+1];
  logic [NW-1:0] dnear_r [QW+1];
  logic          dzero_r [QW+1];
  logic          dsat_r  [QW+1];

  always_ff @(posedge clk) begin
    if (adv_i) begin
      drem_r[0]  <= num_w;
      quo_r[0]   <= '0;
      dnear_r[0] <= rnear_r[SW-1];
      dzero_r[0] <= rzero_r[SW-1];
      dsat_r[0]  <= (rnear_r[SW-1] == '0) || (num_w >= lim_w);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [DW-1:0] cmp;
    logic          ge;
    assign cmp = DW'(dnear_r[k]) << B;
    assign ge  = drem_r[k] >= cmp;
    always_ff @(posedge clk) begin
      if (adv_i) begin
        drem_r[k+1]  <= ge ? drem_r[k] - cmp : drem_r[k];
        quo_r[k+1]   <= ge ? (quo_r[k] | (QW'(1) << B)) : quo_r[k];
        dnear_r[k+1] <= dnear_r[k];
        dzero_r[k+1] <= dzero_r[k];
        dsat_r[k+1]  <= dsat_r[k];
      end
    end
  end

  // Coincident points win over a zero or tiny nearest distance
  logic [QW-1:0] term_w;
  always_comb begin
    priority if (dzero_r[QW]) term_w = '0;
    else if (dsat_r[QW])      term_w = msc_pkg::COST_MAX;
    else                      term_w = quo_r[QW];
  end

  if (PAD > 0) begin : g_pad
    logic [QW-1:0] pterm_r [PAD];
    always_ff @(posedge clk) begin
      if (adv_i) begin
        pterm_r[0] <= term_w;
        for (int i = 1; i < PAD; i++) pterm_r[i] <= pterm_r[i-1];
      end
    end
    assign term_o = pterm_r[PAD-1];
  end else begin : g_nopad
    assign term_o = term_w;
  end

endmodule

`default_nettype wire

[sv/msc_obuf.sv]
// Two-entry result buffer that parts the pipeline from the output channel.
// Depends on msc_pkg.
`default_nettype none

module msc_obuf (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_i,
  input  msc_pkg::out_item_t           wr_data_i,
  output logic                         full_o,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [msc_pkg::OUT_W-1:0]    out_tdata
);

  msc_pkg::out_item_t mem_r [2];
  logic               wptr_r, rptr_r;
  logic [1:0]         count_r, count_nxt;
  logic               rd;

  assign rd         = out_tvalid && out_tready;
  assign out_tvalid = (count_r != 2'd0);
  assign full_o     = (count_r == 2'd2);
  assign out_tdata  = mem_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_i && !rd) count_nxt = count_r + 2'd1;
    if (!wr_i && rd) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (wr_i) wptr_r <= ~wptr_r;
      if (rd)   rptr_r <= ~rptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i) mem_r[wptr_r] <= wr_data_i;
  end

endmodule

`default_nettype wire

[sv/matting_sample_cost.sv]
// Top level of the matting sample-pair cost pipeline.
// Depends on msc_pkg, msc_front, msc_color, msc_space and msc_obuf.
//
// Usage:
//   Each input request carries one foreground/background sample pair for one
//   unknown pixel (colours, coordinates, nearest-boundary distances and the
//   current best cost). Each request yields exactly one result request with
//   alpha (Q1.15), the saturating Q14.16 cost and a flag that marks a new best.
//   Throughput: one request per cycle while the result buffer is not full. The
//   pipeline depth is set by the spatial path, a 29-stage square root followed
//   by a 30-stage quotient, one result bit per stage.
//   Reset (rst_n low at a clock edge) drops every request in flight and
//   empties the result buffer; in_tready stays low while rst_n is low, and
//   the data path registers themselves are not reset.
//   A two-entry buffer holds results for the receiver. While the receiver
//   stalls, the pipeline keeps taking requests until the buffer fills, then
//   holds every stage in place and drops in_tready; nothing is lost or
//   repeated, and the pipeline resumes as soon as the buffer has room again.
`default_nettype none

module matting_sample_cost (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // fg_color, bg_color, pixel_color, pixel_x, pixel_y, fg_x, fg_y, bg_x, bg_y,
  // fg_nearest, bg_nearest, best_cost
  input  logic [msc_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // alpha, cost, better, one zero pad bit
  output logic [msc_pkg::OUT_W-1:0]     out_tdata
);

  localparam int DEPTH  = msc_pkg::PIPE_DEPTH;
  localparam int CW     = msc_pkg::COST_W;
  localparam int CR_W   = msc_pkg::CROOT_W;
  localparam int AW     = msc_pkg::ALPHA_W;
  localparam int WIDE_W = CR_W + CW;

  msc_pkg::in_item_t   item;
  msc_pkg::color_in_t  col;
  msc_pkg::space_in_t  spf, spb;
  msc_pkg::out_item_t  res;
  logic                adv, full;
  logic [AW-1:0]       alpha_p;
  logic [CR_W-1:0]     color_p;
  logic [CW-1:0]       sf_p, sb_p, color_sat;
  logic [WIDE_W-1:0]   color_wide;

  assign item      = msc_pkg::in_item_t'(in_tdata);
  // Advance every stage together; hold all of them while the buffer is full
  assign adv       = !full;
  // Take no request while reset clears the valid bits
  assign in_tready = adv && rst_n;

  msc_front u_front (
    .clk    (clk),
    .adv_i  (adv),
    .item_i (item),
    .col_o  (col),
    .spf_o  (spf),
    .spb_o  (spb)
  );

  msc_color u_color (
    .clk     (clk),
    .adv_i   (adv),
    .col_i   (col),
    .alpha_o (alpha_p),
    .color_o (color_p)
  );

  msc_space u_space_fg (
    .clk    (clk),
    .adv_i  (adv),
    .sp_i   (spf),
    .term_o (sf_p)
  );

  msc_space u_space_bg (
    .clk    (clk),
    .adv_i  (adv),
    .sp_i   (spb),
    .term_o (sb_p)
  );

  // Valid bits and best cost ride alongside the data
  logic [DEPTH-1:0] v_r;
  logic [CW-1:0]    best_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      best_r[0] <= item.best_cost;
      for (int i = 1; i < DEPTH; i++) best_r[i] <= best_r[i-1];
    end
  end

  // Clamp the colour term, then add the two spatial terms over two stages
  assign color_wide = WIDE_W'(color_p);
  assign color_sat  = (color_wide > WIDE_W'(msc_pkg::COST_MAX)) ? msc_pkg::COST_MAX
                                                                : CW'(color_wide);

  logic [CW-1:0] t1_r, sb_r, total_r;
  logic [AW-1:0] alpha_a_r, alpha_b_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r      <= msc_pkg::sat_add(color_sat, sf_p);
      sb_r      <= sb_p;
      alpha_a_r <= alpha_p;
      total_r   <= msc_pkg::sat_add(t1_r, sb_r);
      alpha_b_r <= alpha_a_r;
    end
  end

  // An all-ones best means no best yet
  always_comb begin
    res.spare  = 1'b0;
    res.alpha  = alpha_b_r;
    res.cost   = total_r;
    res.better = (best_r[DEPTH-1] == msc_pkg::COST_MAX) || (total_r < best_r[DEPTH-1]);
  end

  msc_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_i       (adv && v_r[DEPTH-1]),
    .wr_data_i  (res),
    .full_o     (full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
